// ----- rtl/spr_pkg.sv -----
// Shared constants, types and helpers of the saved-phase rephaser.
`default_nettype none

package spr_pkg;

    // Table geometry
    localparam int MAX_VARS = 1024;
    localparam int ADDR_W   = $clog2(MAX_VARS);
    localparam int IDX_W    = 11;

    // Field widths
    localparam int LIM_W      = 48;
    localparam int STEP_W     = 24;
    localparam int HASH_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_POS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USED_VARS   = 3'd5;

    // Configuration reset values
    localparam logic [STEP_W-1:0] RST_INC_STEP    = 24'd1000;
    localparam logic [LIM_W-1:0]  RST_FIRST_LIMIT = 48'd1000;
    localparam logic [IDX_W-1:0]  RST_USED_VARS   = 11'd1024;

    // Commands
    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Rephase modes
    localparam logic [1:0] MODE_ORIG = 2'd0;
    localparam logic [1:0] MODE_FLIP = 2'd1;
    localparam logic [1:0] MODE_INV  = 2'd2;
    localparam logic [1:0] MODE_RAND = 2'd3;

    // Hash multipliers
    localparam logic [HASH_W-1:0] HASH_A = 32'd123123311;
    localparam logic [HASH_W-1:0] HASH_B = 32'd558064459;
    localparam logic [HASH_W-1:0] HASH_C = 32'd43243507;

    // Hash unit operations
    localparam logic [2:0] HOP_MUL_A    = 3'd0;
    localparam logic [2:0] HOP_ADD_SEED = 3'd1;
    localparam logic [2:0] HOP_MUL_B    = 3'd2;
    localparam logic [2:0] HOP_MUL_C    = 3'd3;
    localparam logic [2:0] HOP_ADD_C    = 3'd4;

    typedef struct packed {
        logic       en;
        logic [2:0] op;
    } spr_hash_ctrl_t;

    localparam logic [LIM_W-1:0] LIM_MAX = {LIM_W{1'b1}};

    // Saturating add on the limit width
    function automatic logic [LIM_W-1:0] sat_add(input logic [LIM_W-1:0] a,
                                                 input logic [LIM_W-1:0] b);
        logic [LIM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LIM_W] ? LIM_MAX : s[LIM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/spr_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module spr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word, old data on a collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/spr_hash.sv -----
// Shared multiply/add unit that builds the random-phase hash.
`default_nettype none

module spr_hash
    import spr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire spr_hash_ctrl_t       ctrl,
    input  wire logic [HASH_W-1:0]    counter,
    input  wire logic [HASH_W-1:0]    seed,
    output logic      [HASH_W-1:0]    hash
);

    logic [HASH_W-1:0]   prod_reg;
    logic [HASH_W-1:0]   prod_next;
    logic [HASH_W-1:0]   mul_a;
    logic [HASH_W-1:0]   mul_b;
    logic [2*HASH_W-1:0] mul_full;

    // Pick multiplier operands
    always_comb begin
        mul_a = prod_reg;
        mul_b = HASH_B;
        unique case (ctrl.op)
            HOP_MUL_A: begin
                mul_a = counter;
                mul_b = HASH_A;
            end
            HOP_MUL_C: mul_b = HASH_C;
            default:   mul_b = HASH_B;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Apply one operation per cycle; hold otherwise
    always_comb begin
        prod_next = prod_reg;
        if (ctrl.en) begin
            unique case (ctrl.op)
                HOP_MUL_A, HOP_MUL_B, HOP_MUL_C: prod_next = mul_full[HASH_W-1:0];
                HOP_ADD_SEED:                    prod_next = prod_reg + seed;
                HOP_ADD_C:                       prod_next = prod_reg + HASH_C;
                default:                         prod_next = prod_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign hash = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/sat_phase_rephaser.sv -----
// Top level: saved-phase table with periodic rephasing under a small sequencer.
// A write, an unknown command or a quiet check goes straight to the result; a read first
// reads the table; a rephase runs the hash steps, an n-entry sweep (skipped when n is 0)
// and the limit update, where n = min(used_vars, MAX_VARS) and the sweep rewrites one table
// entry per cycle. No beat is taken mid-item; one more is taken while a result waits.
// Reset (synchronous, aresetn low) runs a pass that sets all MAX_VARS (1024) entries
// positive; s_tready stays low during it, configuration writes are taken.
`default_nettype none

module sat_phase_rephaser
    import spr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: conflict_count[47:0], var_index[58:48], phase_in[59], zero pad[63:60]
    input  wire logic [63:0]           s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [1:0]            s_tuser,
    // Result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: did_rephase[0], rephase_mode[2:1], phase_out[3], next_limit[51:4],
    //          zero pad[55:52]
    output logic      [55:0]           m_tdata,
    // Configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer states
    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_RD      = 4'd2;
    localparam logic [3:0] ST_RD_DATA = 4'd3;
    localparam logic [3:0] ST_MUL1    = 4'd4;
    localparam logic [3:0] ST_ADDS    = 4'd5;
    localparam logic [3:0] ST_MUL2    = 4'd6;
    localparam logic [3:0] ST_MUL3    = 4'd7;
    localparam logic [3:0] ST_SWEEP   = 4'd8;
    localparam logic [3:0] ST_DRAIN   = 4'd9;
    localparam logic [3:0] ST_INC     = 4'd10;
    localparam logic [3:0] ST_LIM     = 4'd11;
    localparam logic [3:0] ST_FIX     = 4'd12;
    localparam logic [3:0] ST_DONE    = 4'd13;

    // Control and configuration
    logic [3:0]        state_reg,      state_next;
    logic [IDX_W-1:0]  idx_reg,        idx_next;
    logic              s1_valid_reg,   s1_valid_next;
    logic              m_valid_reg,    m_valid_next;
    logic              enable_reg,     enable_next;
    logic              dflt_pos_reg,   dflt_pos_next;
    logic [HASH_W-1:0] seed_reg,       seed_next;
    logic [STEP_W-1:0] step_reg,       step_next;
    logic [IDX_W-1:0]  used_vars_reg,  used_vars_next;
    logic [HASH_W-1:0] counter_reg,    counter_next;
    logic [LIM_W-1:0]  inc_reg,        inc_next;
    logic [LIM_W-1:0]  limit_reg,      limit_next;

    // Item and result payload
    logic [IDX_W-1:0]  item_idx_reg,   item_idx_next;
    logic              idx_ok_reg,     idx_ok_next;
    logic [LIM_W-1:0]  count_reg,      count_next;
    logic [1:0]        mode_reg,       mode_next;
    logic [IDX_W-1:0]  n_reg,          n_next;
    logic [ADDR_W-1:0] s1_addr_reg,    s1_addr_next;
    logic              res_did_reg,    res_did_next;
    logic [1:0]        res_mode_reg,   res_mode_next;
    logic              res_phase_reg,  res_phase_next;
    logic              m_did_reg,      m_did_next;
    logic [1:0]        m_mode_reg,     m_mode_next;
    logic              m_phase_reg,    m_phase_next;
    logic [LIM_W-1:0]  m_limit_reg,    m_limit_next;

    // Table port signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    // Hash unit
    spr_hash_ctrl_t    hash_ctrl;
    logic [HASH_W-1:0] hash_val;

    // Input unpacking and derived values
    logic              s_accept;
    logic [1:0]        in_cmd;
    logic [LIM_W-1:0]  in_count;
    logic [IDX_W-1:0]  in_idx;
    logic              in_phase;
    logic              in_idx_ok;
    logic              in_trigger;
    logic [IDX_W-1:0]  in_idx_m1;
    logic [IDX_W-1:0]  idx_m1;
    logic [IDX_W-1:0]  item_idx_m1;
    logic [IDX_W-1:0]  n_clamped;
    logic [HASH_W-1:0] counter_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_cmd   = s_tuser;
    assign in_count = s_tdata[47:0];
    assign in_idx   = s_tdata[58:48];
    assign in_phase = s_tdata[59];

    assign in_idx_ok   = (in_idx != '0) && (in_idx <= IDX_W'(MAX_VARS));
    assign in_trigger  = enable_reg && (in_count > limit_reg);
    assign in_idx_m1   = in_idx - IDX_W'(1);
    assign idx_m1      = idx_reg - IDX_W'(1);
    assign item_idx_m1 = item_idx_reg - IDX_W'(1);
    assign n_clamped   = (used_vars_reg > IDX_W'(MAX_VARS)) ? IDX_W'(MAX_VARS)
                                                            : used_vars_reg;
    assign counter_inc = counter_reg + HASH_W'(1);

    // Read address: sweep position, else the latched item index
    assign ram_raddr = (state_reg == ST_SWEEP) ? idx_m1[ADDR_W-1:0]
                                               : item_idx_m1[ADDR_W-1:0];

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        s1_valid_next  = 1'b0;
        m_valid_next   = m_valid_reg && !m_tready;
        enable_next    = enable_reg;
        dflt_pos_next  = dflt_pos_reg;
        seed_next      = seed_reg;
        step_next      = step_reg;
        used_vars_next = used_vars_reg;
        counter_next   = counter_reg;
        inc_next       = inc_reg;
        limit_next     = limit_reg;
        item_idx_next  = item_idx_reg;
        idx_ok_next    = idx_ok_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        n_next         = n_reg;
        s1_addr_next   = s1_addr_reg;
        res_did_next   = res_did_reg;
        res_mode_next  = res_mode_reg;
        res_phase_next = res_phase_reg;
        m_did_next     = m_did_reg;
        m_mode_next    = m_mode_reg;
        m_phase_next   = m_phase_reg;
        m_limit_next   = m_limit_reg;
        hash_ctrl      = '{en: 1'b0, op: HOP_ADD_C};

        // Sweep write stage: rewrite the entry read in the previous cycle
        ram_we    = s1_valid_reg;
        ram_waddr = s1_addr_reg;
        unique case (mode_reg)
            MODE_ORIG: ram_wdata = dflt_pos_reg;
            MODE_FLIP: ram_wdata = ~ram_rdata;
            MODE_INV:  ram_wdata = ~dflt_pos_reg;
            MODE_RAND: ram_wdata = ~(^hash_val);
            default:   ram_wdata = dflt_pos_reg;
        endcase

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[ADDR_W-1:0];
                ram_wdata = 1'b1;
                if (idx_reg == IDX_W'(MAX_VARS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    item_idx_next  = in_idx;
                    idx_ok_next    = in_idx_ok;
                    count_next     = in_count;
                    res_did_next   = 1'b0;
                    res_mode_next  = MODE_ORIG;
                    res_phase_next = 1'b0;
                    state_next     = ST_DONE;
                    unique case (in_cmd)
                        CMD_CHECK: begin
                            if (in_trigger) begin
                                counter_next = counter_inc;
                                mode_next    = counter_inc[1:0];
                                n_next       = n_clamped;
                                state_next   = ST_MUL1;
                            end
                        end
                        CMD_WRITE: begin
                            if (in_idx_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = in_idx_m1[ADDR_W-1:0];
                                ram_wdata = in_phase;
                            end
                        end
                        CMD_READ: state_next = ST_RD;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD: state_next = ST_RD_DATA;
            ST_RD_DATA: begin
                res_phase_next = idx_ok_reg & ram_rdata;
                state_next     = ST_DONE;
            end
            // Hash base: ((counter * A) + seed) * B * C
            ST_MUL1: begin
                hash_ctrl  = '{en: 1'b1, op: HOP_MUL_A};
                state_next = ST_ADDS;
            end
            ST_ADDS: begin
                hash_ctrl  = '{en: 1'b1, op: HOP_ADD_SEED};
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                hash_ctrl  = '{en: 1'b1, op: HOP_MUL_B};
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                hash_ctrl = '{en: 1'b1, op: HOP_MUL_C};
                idx_next  = IDX_W'(1);
                if (n_reg == '0) begin
                    state_next = ST_INC;
                end else begin
                    state_next = ST_SWEEP;
                end
            end
            // Read one entry per cycle; the hash steps by C with the index
            ST_SWEEP: begin
                hash_ctrl     = '{en: 1'b1, op: HOP_ADD_C};
                s1_valid_next = 1'b1;
                s1_addr_next  = idx_m1[ADDR_W-1:0];
                if (idx_reg == n_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: state_next = ST_INC;
            // Limit update, one wide add per cycle
            ST_INC: begin
                inc_next   = sat_add(inc_reg, LIM_W'(step_reg));
                state_next = ST_LIM;
            end
            ST_LIM: begin
                limit_next = sat_add(limit_reg, inc_reg);
                state_next = ST_FIX;
            end
            ST_FIX: begin
                if (limit_reg <= count_reg) begin
                    limit_next = sat_add(count_reg, LIM_W'(1));
                end
                res_did_next  = 1'b1;
                res_mode_next = mode_reg;
                state_next    = ST_DONE;
            end
            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_did_next   = res_did_reg;
                    m_mode_next  = res_mode_reg;
                    m_phase_next = res_phase_reg;
                    m_limit_next = limit_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Configuration writes; a new first limit reloads the conflict limit
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENABLE:      enable_next    = cfg_data[0];
                CFG_DEFAULT_POS: dflt_pos_next  = cfg_data[0];
                CFG_HASH_SEED:   seed_next      = cfg_data[HASH_W-1:0];
                CFG_INC_STEP:    step_next      = cfg_data[STEP_W-1:0];
                CFG_FIRST_LIMIT: limit_next     = cfg_data[LIM_W-1:0];
                CFG_USED_VARS:   used_vars_next = cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            enable_reg    <= 1'b1;
            dflt_pos_reg  <= 1'b1;
            seed_reg      <= '0;
            step_reg      <= RST_INC_STEP;
            used_vars_reg <= RST_USED_VARS;
            counter_reg   <= '0;
            inc_reg       <= '0;
            limit_reg     <= RST_FIRST_LIMIT;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
            enable_reg    <= enable_next;
            dflt_pos_reg  <= dflt_pos_next;
            seed_reg      <= seed_next;
            step_reg      <= step_next;
            used_vars_reg <= used_vars_next;
            counter_reg   <= counter_next;
            inc_reg       <= inc_next;
            limit_reg     <= limit_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_idx_reg  <= item_idx_next;
        idx_ok_reg    <= idx_ok_next;
        count_reg     <= count_next;
        mode_reg      <= mode_next;
        n_reg         <= n_next;
        s1_addr_reg   <= s1_addr_next;
        res_did_reg   <= res_did_next;
        res_mode_reg  <= res_mode_next;
        res_phase_reg <= res_phase_next;
        m_did_reg     <= m_did_next;
        m_mode_reg    <= m_mode_next;
        m_phase_reg   <= m_phase_next;
        m_limit_reg   <= m_limit_next;
    end

    // Phase table
    spr_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VARS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Random-phase hash
    spr_hash u_hash (
        .aclk    (aclk),
        .ctrl    (hash_ctrl),
        .counter (counter_reg),
        .seed    (seed_reg),
        .hash    (hash_val)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_limit_reg, m_phase_reg, m_mode_reg, m_did_reg};

endmodule

`default_nettype wire

// ----- rtl/spr_checker.sv -----
// Port-level checks of the rephaser, bound to the top level.
`default_nettype none

module spr_checker
    import spr_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [55:0]           m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: ready drops after each accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted beat");

    // A result without a rephase reports mode original
    a_mode_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == MODE_ORIG)
        else $error("mode set without a rephase");

    // A rephase result never carries a read phase
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[3]))
        else $error("rephase and read phase in one result");

endmodule

bind sat_phase_rephaser spr_checker u_spr_checker (.*);

`default_nettype wire
